// ===== rtl/svpi_pkg.sv =====
// shared types for the segment versus vertical panel crossing test
`timescale 1ns / 1ps

package svpi_pkg;

    // per-request status carried alongside the height datapath
    typedef struct packed {
        logic degenerate;
        logic n_ok;
        logic m_ok;
    } svpi_flags_t;

endpackage

// ===== rtl/svpi_diff_mul.sv =====
// coordinate differences and first-level cross products (two stages)
`timescale 1ns / 1ps

module svpi_diff_mul
    import svpi_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  logic signed [COORD_WIDTH-1:0] edge_ax,
    input  logic signed [COORD_WIDTH-1:0] edge_ay,
    input  logic signed [COORD_WIDTH-1:0] edge_bx,
    input  logic signed [COORD_WIDTH-1:0] edge_by,
    input  logic signed [COORD_WIDTH-1:0] floor_z,
    input  logic signed [COORD_WIDTH-1:0] ceiling_z,
    input  logic signed [COORD_WIDTH-1:0] start_x,
    input  logic signed [COORD_WIDTH-1:0] start_y,
    input  logic signed [COORD_WIDTH-1:0] start_z,
    input  logic signed [COORD_WIDTH-1:0] end_x,
    input  logic signed [COORD_WIDTH-1:0] end_y,
    input  logic signed [COORD_WIDTH-1:0] end_z,
    output logic                          dn_valid,
    input  logic                          dn_ready,
    output logic signed [2*COORD_WIDTH+1:0] p_lyex,
    output logic signed [2*COORD_WIDTH+1:0] p_lxey,
    output logic signed [2*COORD_WIDTH+1:0] p_dxey,
    output logic signed [2*COORD_WIDTH+1:0] p_dyex,
    output logic signed [2*COORD_WIDTH+1:0] p_dxly,
    output logic signed [2*COORD_WIDTH+1:0] p_dylx,
    output logic signed [COORD_WIDTH:0]   h,
    output logic signed [COORD_WIDTH:0]   lz,
    output logic signed [COORD_WIDTH:0]   dz
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    logic          v1_reg, v1_next, v2_reg, v2_next;
    logic          en1, en2;

    logic signed [DW-1:0] ex_next, ey_next, h_next, lx_next, ly_next, lz_next;
    logic signed [DW-1:0] dx_next, dy_next, dz_next;
    logic signed [DW-1:0] ex_reg, ey_reg, h_reg, lx_reg, ly_reg, lz_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, dz_reg;

    logic signed [PW-1:0] lyex_next, lxey_next, dxey_next, dyex_next, dxly_next, dylx_next;
    logic signed [PW-1:0] lyex_reg, lxey_reg, dxey_reg, dyex_reg, dxly_reg, dylx_reg;
    logic signed [DW-1:0] h2_reg, lz2_reg, dz2_reg;

    assign en2      = !v2_reg || dn_ready;
    assign en1      = !v1_reg || en2;
    assign up_ready = en1;
    assign v1_next  = en1 ? up_valid : v1_reg;
    assign v2_next  = en2 ? v1_reg : v2_reg;

    // sign-extended differences, exact in one extra bit
    assign ex_next = {edge_bx[COORD_WIDTH-1], edge_bx} - {edge_ax[COORD_WIDTH-1], edge_ax};
    assign ey_next = {edge_by[COORD_WIDTH-1], edge_by} - {edge_ay[COORD_WIDTH-1], edge_ay};
    assign h_next  = {ceiling_z[COORD_WIDTH-1], ceiling_z} - {floor_z[COORD_WIDTH-1], floor_z};
    assign lx_next = {end_x[COORD_WIDTH-1], end_x} - {start_x[COORD_WIDTH-1], start_x};
    assign ly_next = {end_y[COORD_WIDTH-1], end_y} - {start_y[COORD_WIDTH-1], start_y};
    assign lz_next = {end_z[COORD_WIDTH-1], end_z} - {start_z[COORD_WIDTH-1], start_z};
    assign dx_next = {start_x[COORD_WIDTH-1], start_x} - {edge_ax[COORD_WIDTH-1], edge_ax};
    assign dy_next = {start_y[COORD_WIDTH-1], start_y} - {edge_ay[COORD_WIDTH-1], edge_ay};
    assign dz_next = {start_z[COORD_WIDTH-1], start_z} - {floor_z[COORD_WIDTH-1], floor_z};

    assign lyex_next = ly_reg * ex_reg;
    assign lxey_next = lx_reg * ey_reg;
    assign dxey_next = dx_reg * ey_reg;
    assign dyex_next = dy_reg * ex_reg;
    assign dxly_next = dx_reg * ly_reg;
    assign dylx_next = dy_reg * lx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            ex_reg <= ex_next;
            ey_reg <= ey_next;
            h_reg  <= h_next;
            lx_reg <= lx_next;
            ly_reg <= ly_next;
            lz_reg <= lz_next;
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            dz_reg <= dz_next;
        end
        if (en2)
        begin
            lyex_reg <= lyex_next;
            lxey_reg <= lxey_next;
            dxey_reg <= dxey_next;
            dyex_reg <= dyex_next;
            dxly_reg <= dxly_next;
            dylx_reg <= dylx_next;
            h2_reg   <= h_reg;
            lz2_reg  <= lz_reg;
            dz2_reg  <= dz_reg;
        end
    end

    assign dn_valid = v2_reg;
    assign p_lyex   = lyex_reg;
    assign p_lxey   = lxey_reg;
    assign p_dxey   = dxey_reg;
    assign p_dyex   = dyex_reg;
    assign p_dxly   = dxly_reg;
    assign p_dylx   = dylx_reg;
    assign h        = h2_reg;
    assign lz       = lz2_reg;
    assign dz       = dz2_reg;

endmodule

// ===== rtl/svpi_cross_norm.sv =====
// cross-product sums and divisor sign normalization (two stages)
`timescale 1ns / 1ps

module svpi_cross_norm
    import svpi_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            up_valid,
    output logic                            up_ready,
    input  logic signed [2*COORD_WIDTH+1:0] p_lyex,
    input  logic signed [2*COORD_WIDTH+1:0] p_lxey,
    input  logic signed [2*COORD_WIDTH+1:0] p_dxey,
    input  logic signed [2*COORD_WIDTH+1:0] p_dyex,
    input  logic signed [2*COORD_WIDTH+1:0] p_dxly,
    input  logic signed [2*COORD_WIDTH+1:0] p_dylx,
    input  logic signed [COORD_WIDTH:0]     h_prev,
    input  logic signed [COORD_WIDTH:0]     lz_prev,
    input  logic signed [COORD_WIDTH:0]     dz_prev,
    output logic                            dn_valid,
    input  logic                            dn_ready,
    output logic signed [2*COORD_WIDTH+2:0] n,
    output logic signed [2*COORD_WIDTH+2:0] c,
    output logic signed [2*COORD_WIDTH+2:0] m,
    output logic signed [COORD_WIDTH:0]     h,
    output logic signed [COORD_WIDTH:0]     lz,
    output logic signed [COORD_WIDTH:0]     dz,
    output logic                            degenerate
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int CW = 2 * COORD_WIDTH + 3;

    logic v3_reg, v3_next, v4_reg, v4_next;
    logic en3, en4;

    logic signed [CW-1:0] n3_next, c3_next, m3_next;
    logic signed [CW-1:0] n3_reg, c3_reg, m3_reg;
    logic signed [DW-1:0] h3_reg, lz3_reg, dz3_reg;

    logic                 flip;
    logic signed [CW-1:0] n4_next, c4_next, m4_next;
    logic                 deg4_next;
    logic signed [CW-1:0] n4_reg, c4_reg, m4_reg;
    logic signed [DW-1:0] h4_reg, lz4_reg, dz4_reg;
    logic                 deg4_reg;

    assign en4      = !v4_reg || dn_ready;
    assign en3      = !v3_reg || en4;
    assign up_ready = en3;
    assign v3_next  = en3 ? up_valid : v3_reg;
    assign v4_next  = en4 ? v3_reg : v4_reg;

    // n: plane crossing numerator, c: divisor, m: edge fraction numerator
    assign n3_next = CW'(p_dxey) - CW'(p_dyex);
    assign c3_next = CW'(p_lyex) - CW'(p_lxey);
    assign m3_next = CW'(p_dxly) - CW'(p_dylx);

    // make the divisor positive
    assign flip      = c3_reg[CW-1];
    assign c4_next   = flip ? -c3_reg : c3_reg;
    assign n4_next   = flip ? -n3_reg : n3_reg;
    assign m4_next   = flip ? -m3_reg : m3_reg;
    assign deg4_next = (h3_reg == '0) || (c3_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            n3_reg  <= n3_next;
            c3_reg  <= c3_next;
            m3_reg  <= m3_next;
            h3_reg  <= h_prev;
            lz3_reg <= lz_prev;
            dz3_reg <= dz_prev;
        end
        if (en4)
        begin
            n4_reg   <= n4_next;
            c4_reg   <= c4_next;
            m4_reg   <= m4_next;
            h4_reg   <= h3_reg;
            lz4_reg  <= lz3_reg;
            dz4_reg  <= dz3_reg;
            deg4_reg <= deg4_next;
        end
    end

    assign dn_valid   = v4_reg;
    assign n          = n4_reg;
    assign c          = c4_reg;
    assign m          = m4_reg;
    assign h          = h4_reg;
    assign lz         = lz4_reg;
    assign dz         = dz4_reg;
    assign degenerate = deg4_reg;

endmodule

// ===== rtl/svpi_height.sv =====
// unit-range checks on n and m, split products for the height test (two stages)
`timescale 1ns / 1ps

module svpi_height
    import svpi_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            up_valid,
    output logic                            up_ready,
    input  logic signed [2*COORD_WIDTH+2:0] n,
    input  logic signed [2*COORD_WIDTH+2:0] c,
    input  logic signed [2*COORD_WIDTH+2:0] m,
    input  logic signed [COORD_WIDTH:0]     h,
    input  logic signed [COORD_WIDTH:0]     lz,
    input  logic signed [COORD_WIDTH:0]     dz,
    input  logic                            degenerate,
    output logic                            dn_valid,
    input  logic                            dn_ready,
    output logic signed [3*COORD_WIDTH+5:0] q,
    output logic signed [3*COORD_WIDTH+5:0] hc,
    output svpi_flags_t                     flags
);

    localparam int CW  = 2 * COORD_WIDTH + 3;
    localparam int KL  = COORD_WIDTH + 1;
    localparam int PPW = 2 * COORD_WIDTH + 3;
    localparam int QW  = 3 * COORD_WIDTH + 6;

    logic v5_reg, v5_next, v6_reg, v6_next;
    logic en5, en6;

    // low halves taken as unsigned, high halves keep the sign
    logic signed [KL:0]      c_lo, n_lo;
    logic signed [CW-KL-1:0] c_hi, n_hi;
    logic signed [CW:0]      cn_diff, cm_diff;
    svpi_flags_t             flags5_next;

    logic signed [PPW-1:0] dzcl_next, dzch_next, lznl_next, lznh_next, hcl_next, hch_next;
    logic signed [PPW-1:0] dzcl_reg, dzch_reg, lznl_reg, lznh_reg, hcl_reg, hch_reg;
    svpi_flags_t           flags5_reg;

    logic signed [QW-1:0] q6_next, hc6_next;
    logic signed [QW-1:0] q6_reg, hc6_reg;
    svpi_flags_t          flags6_reg;

    assign en6      = !v6_reg || dn_ready;
    assign en5      = !v5_reg || en6;
    assign up_ready = en5;
    assign v5_next  = en5 ? up_valid : v5_reg;
    assign v6_next  = en6 ? v5_reg : v6_reg;

    assign c_lo = {1'b0, c[KL-1:0]};
    assign n_lo = {1'b0, n[KL-1:0]};
    assign c_hi = c[CW-1:KL];
    assign n_hi = n[CW-1:KL];

    // c is positive here, so the bounds are 0 <= x <= c
    assign cn_diff = {c[CW-1], c} - {n[CW-1], n};
    assign cm_diff = {c[CW-1], c} - {m[CW-1], m};

    assign flags5_next.degenerate = degenerate;
    assign flags5_next.n_ok       = !n[CW-1] && !cn_diff[CW];
    assign flags5_next.m_ok       = !m[CW-1] && !cm_diff[CW];

    assign dzcl_next = dz * c_lo;
    assign dzch_next = dz * c_hi;
    assign lznl_next = lz * n_lo;
    assign lznh_next = lz * n_hi;
    assign hcl_next  = h * c_lo;
    assign hch_next  = h * c_hi;

    // recombine partial products: height numerator dz*c + n*lz, divisor h*c
    assign q6_next  = (QW'(dzch_reg) <<< KL) + QW'(dzcl_reg)
                    + (QW'(lznh_reg) <<< KL) + QW'(lznl_reg);
    assign hc6_next = (QW'(hch_reg) <<< KL) + QW'(hcl_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= v5_next;
            v6_reg <= v6_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            dzcl_reg   <= dzcl_next;
            dzch_reg   <= dzch_next;
            lznl_reg   <= lznl_next;
            lznh_reg   <= lznh_next;
            hcl_reg    <= hcl_next;
            hch_reg    <= hch_next;
            flags5_reg <= flags5_next;
        end
        if (en6)
        begin
            q6_reg     <= q6_next;
            hc6_reg    <= hc6_next;
            flags6_reg <= flags5_reg;
        end
    end

    assign dn_valid = v6_reg;
    assign q        = q6_reg;
    assign hc       = hc6_reg;
    assign flags    = flags6_reg;

endmodule

// ===== rtl/svpi_decide.sv =====
// height bound check and output register
`timescale 1ns / 1ps

module svpi_decide
    import svpi_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            up_valid,
    output logic                            up_ready,
    input  logic signed [3*COORD_WIDTH+5:0] q,
    input  logic signed [3*COORD_WIDTH+5:0] hc,
    input  svpi_flags_t                     flags,
    output logic                            dn_valid,
    input  logic                            dn_ready,
    output logic                            hit,
    output logic                            degenerate
);

    localparam int QW = 3 * COORD_WIDTH + 6;

    logic                 v7_reg, v7_next, en7;
    logic signed [QW-1:0] hc_minus_q, q_minus_hc;
    logic                 q_ok;
    logic                 hit_next;
    logic                 hit_reg, deg_reg;

    assign en7      = !v7_reg || dn_ready;
    assign up_ready = en7;
    assign v7_next  = en7 ? up_valid : v7_reg;

    assign hc_minus_q = hc - q;
    assign q_minus_hc = q - hc;

    // positive divisor: 0 <= q <= hc, negative divisor: hc <= q <= 0
    always_comb
    begin
        if (hc[QW-1])
        begin
            q_ok = (q[QW-1] || (q == '0)) && !q_minus_hc[QW-1];
        end
        else
        begin
            q_ok = !q[QW-1] && !hc_minus_q[QW-1];
        end
    end

    assign hit_next = !flags.degenerate && flags.n_ok && flags.m_ok && q_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
        end
        else
        begin
            v7_reg <= v7_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en7)
        begin
            hit_reg <= hit_next;
            deg_reg <= flags.degenerate;
        end
    end

    assign dn_valid   = v7_reg;
    assign hit        = hit_reg;
    assign degenerate = deg_reg;

endmodule

// ===== rtl/segment_vertical_panel_intersect_top.sv =====
// top level of the segment versus vertical wall panel crossing test
`timescale 1ns / 1ps

// usage
//   input channel: in_valid / in_stall, one request = panel edge a-b, floor and
//   ceiling heights, segment start and end, all signed q24.8 coordinates
//   output channel: out_valid / out_stall, one response per request: hit and
//   degenerate (zero height, or zero divisor: parallel, zero edge, zero segment)
//   a transfer happens on a rising edge with valid high and stall low
// stages and throughput
//   seven register stages; with no stalls, one request per cycle is sustained;
//   the stages in order: differences, cross products, sums, sign normalization,
//   split height products, recombination, final compare
// stall behavior
//   each stage holds its data while the next one is full and stalled; bubbles
//   are squeezed out, so requests keep being taken while a response waits until
//   every stage is occupied
// reset
//   rst_n clears all stage valid bits; the block takes a request right after

module segment_vertical_panel_intersect_top
    import svpi_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] edge_ax,
    input  logic signed [COORD_WIDTH-1:0] edge_ay,
    input  logic signed [COORD_WIDTH-1:0] edge_bx,
    input  logic signed [COORD_WIDTH-1:0] edge_by,
    input  logic signed [COORD_WIDTH-1:0] floor_z,
    input  logic signed [COORD_WIDTH-1:0] ceiling_z,
    input  logic signed [COORD_WIDTH-1:0] start_x,
    input  logic signed [COORD_WIDTH-1:0] start_y,
    input  logic signed [COORD_WIDTH-1:0] start_z,
    input  logic signed [COORD_WIDTH-1:0] end_x,
    input  logic signed [COORD_WIDTH-1:0] end_y,
    input  logic signed [COORD_WIDTH-1:0] end_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic                          degenerate
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam int CW = 2 * COORD_WIDTH + 3;
    localparam int QW = 3 * COORD_WIDTH + 6;

    // stage-group handshakes
    logic a_ready, ab_valid, ab_ready, bc_valid, bc_ready, cd_valid, cd_ready;

    // cross products of the differences
    logic signed [PW-1:0] p_lyex, p_lxey, p_dxey, p_dyex, p_dxly, p_dylx;
    logic signed [DW-1:0] ab_h, ab_lz, ab_dz;

    // normalized numerators and positive divisor
    logic signed [CW-1:0] bc_n, bc_c, bc_m;
    logic signed [DW-1:0] bc_h, bc_lz, bc_dz;
    logic                 bc_deg;

    // height numerator and divisor
    logic signed [QW-1:0] cd_q, cd_hc;
    svpi_flags_t          cd_flags;

    assign in_stall = !a_ready;

    svpi_diff_mul #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_diff_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (in_valid),
        .up_ready  (a_ready),
        .edge_ax   (edge_ax),
        .edge_ay   (edge_ay),
        .edge_bx   (edge_bx),
        .edge_by   (edge_by),
        .floor_z   (floor_z),
        .ceiling_z (ceiling_z),
        .start_x   (start_x),
        .start_y   (start_y),
        .start_z   (start_z),
        .end_x     (end_x),
        .end_y     (end_y),
        .end_z     (end_z),
        .dn_valid  (ab_valid),
        .dn_ready  (ab_ready),
        .p_lyex    (p_lyex),
        .p_lxey    (p_lxey),
        .p_dxey    (p_dxey),
        .p_dyex    (p_dyex),
        .p_dxly    (p_dxly),
        .p_dylx    (p_dylx),
        .h         (ab_h),
        .lz        (ab_lz),
        .dz        (ab_dz)
    );

    svpi_cross_norm #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_cross_norm (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (ab_valid),
        .up_ready   (ab_ready),
        .p_lyex     (p_lyex),
        .p_lxey     (p_lxey),
        .p_dxey     (p_dxey),
        .p_dyex     (p_dyex),
        .p_dxly     (p_dxly),
        .p_dylx     (p_dylx),
        .h_prev     (ab_h),
        .lz_prev    (ab_lz),
        .dz_prev    (ab_dz),
        .dn_valid   (bc_valid),
        .dn_ready   (bc_ready),
        .n          (bc_n),
        .c          (bc_c),
        .m          (bc_m),
        .h          (bc_h),
        .lz         (bc_lz),
        .dz         (bc_dz),
        .degenerate (bc_deg)
    );

    svpi_height #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_height (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (bc_valid),
        .up_ready   (bc_ready),
        .n          (bc_n),
        .c          (bc_c),
        .m          (bc_m),
        .h          (bc_h),
        .lz         (bc_lz),
        .dz         (bc_dz),
        .degenerate (bc_deg),
        .dn_valid   (cd_valid),
        .dn_ready   (cd_ready),
        .q          (cd_q),
        .hc         (cd_hc),
        .flags      (cd_flags)
    );

    // final compare doubles as the output register
    svpi_decide #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_decide (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (cd_valid),
        .up_ready   (cd_ready),
        .q          (cd_q),
        .hc         (cd_hc),
        .flags      (cd_flags),
        .dn_valid   (out_valid),
        .dn_ready   (!out_stall),
        .hit        (hit),
        .degenerate (degenerate)
    );

endmodule

// ===== bench/tb.sv =====
// testbench for the segment versus vertical wall panel crossing test
`timescale 1ns / 1ps

// what is checked
//   every request is predicted with exact wide integer arithmetic: the line
//   parameter, the projection along the fence edge and the height fraction are
//   each tested against [0,1] by cross multiplication with a positive divisor,
//   so the expected hit and degenerate bits carry no rounding at all
// how
//   one initial block runs named test tasks in turn; they share send_request,
//   which drives at the falling edge and waits for the handshake, and one
//   checking process compares each response with the oldest prediction
//   the receiver stalls on changing patterns of its own and once holds off for
//   a long stretch so the pipeline fills and stalls its input

module tb;

    localparam int CW = 32;
    localparam int U = 256;                    // one meter in q24.8
    localparam int CMAX = 32'h7fff_ffff;
    localparam int CMIN = -2147483647 - 1;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_REQUESTS = 616;

    typedef logic signed [255:0] wide_t;

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] fl;
        logic signed [CW-1:0] ce;
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] sz;
        logic signed [CW-1:0] tx;
        logic signed [CW-1:0] ty;
        logic signed [CW-1:0] tz;
    } panel_req_t;

    typedef struct packed {
        logic hit;
        logic degenerate;
    } verdict_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_style_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [CW-1:0] edge_ax = '0;
    logic signed [CW-1:0] edge_ay = '0;
    logic signed [CW-1:0] edge_bx = '0;
    logic signed [CW-1:0] edge_by = '0;
    logic signed [CW-1:0] floor_z = '0;
    logic signed [CW-1:0] ceiling_z = '0;
    logic signed [CW-1:0] start_x = '0;
    logic signed [CW-1:0] start_y = '0;
    logic signed [CW-1:0] start_z = '0;
    logic signed [CW-1:0] end_x = '0;
    logic signed [CW-1:0] end_y = '0;
    logic signed [CW-1:0] end_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic hit;
    logic degenerate;

    verdict_t pending_verdicts[$];
    int unsigned fault_count = 0;

    // receiver pattern control, written by the test tasks, the hold-off process and the stall pattern process
    bit stall_enable = 1'b1;
    bit hold_active = 1'b0;
    stall_style_t stall_style = STALL_NONE;
    int unsigned stall_phase_left = 0;
    int unsigned stall_tick = 0;

    segment_vertical_panel_intersect_top #(
        .COORD_WIDTH (CW)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .edge_ax   (edge_ax),
        .edge_ay   (edge_ay),
        .edge_bx   (edge_bx),
        .edge_by   (edge_by),
        .floor_z   (floor_z),
        .ceiling_z (ceiling_z),
        .start_x   (start_x),
        .start_y   (start_y),
        .start_z   (start_z),
        .end_x     (end_x),
        .end_y     (end_y),
        .end_z     (end_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hit       (hit),
        .degenerate(degenerate)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // hard stop in case the handshake hangs
    initial
    begin
        #2000000;
        $display("** segment_vertical_panel_intersect_top: FAILED **");
        $finish;
    end

    // 0 <= p <= q, with q already made positive
    function automatic bit in_closed_unit(wide_t p, wide_t q);
        return (p >= 0) && (p <= q);
    endfunction

    // exact crossing decision for one request
    function automatic verdict_t predict_crossing(panel_req_t r);
        wide_t ex, ey, h, lx, ly, lz, dx, dy, dz;
        wide_t num, den, edge_p, edge_q, ht_p, ht_q;
        verdict_t v;
        ex = longint'(r.bx) - longint'(r.ax);
        ey = longint'(r.by) - longint'(r.ay);
        h  = longint'(r.ce) - longint'(r.fl);
        lx = longint'(r.tx) - longint'(r.sx);
        ly = longint'(r.ty) - longint'(r.sy);
        lz = longint'(r.tz) - longint'(r.sz);
        dx = longint'(r.sx) - longint'(r.ax);
        dy = longint'(r.sy) - longint'(r.ay);
        dz = longint'(r.sz) - longint'(r.fl);
        num = dx * ey - dy * ex;
        den = ly * ex - lx * ey;
        if (h == 0 || den == 0)
        begin
            v.hit = 1'b0;
            v.degenerate = 1'b1;
            return v;
        end
        // keep the line parameter divisor positive
        if (den < 0)
        begin
            den = -den;
            num = -num;
        end
        edge_p = (dx * ex + dy * ey) * den + num * (lx * ex + ly * ey);
        edge_q = (ex * ex + ey * ey) * den;
        ht_p = dz * den + num * lz;
        ht_q = h * den;
        // ceiling below floor flips the height divisor
        if (ht_q < 0)
        begin
            ht_q = -ht_q;
            ht_p = -ht_p;
        end
        v.hit = in_closed_unit(num, den) && in_closed_unit(edge_p, edge_q)
                && in_closed_unit(ht_p, ht_q);
        v.degenerate = 1'b0;
        return v;
    endfunction

    function automatic panel_req_t panel(int ax, int ay, int bx, int by, int fl, int ce,
                                         int sx, int sy, int sz, int tx, int ty, int tz);
        panel_req_t r;
        r.ax = ax; r.ay = ay; r.bx = bx; r.by = by; r.fl = fl; r.ce = ce;
        r.sx = sx; r.sy = sy; r.sz = sz; r.tx = tx; r.ty = ty; r.tz = tz;
        return r;
    endfunction

    function automatic int srange(int mag);
        int v;
        v = $urandom_range(0, 2 * mag);
        return v - mag;
    endfunction

    // boundary-heavy value for a single coordinate
    function automatic int pick_corner_value();
        case ($urandom_range(0, 5))
            0: return CMAX;
            1: return CMIN;
            2: return 0;
            3: return -1;
            4: return 1;
            default: return $urandom;
        endcase
    endfunction

    // segment aimed at a lattice point on or just beside the panel, so the
    // boundaries of all three fractions are hit exactly fairly often
    function automatic panel_req_t aimed_panel(int mag);
        int ax, ay, ex, ey, fl, h, px, py, pz, vx, vy, vz, k, j, a, b;
        ax = srange(mag);
        ay = srange(mag);
        ex = 8 * srange(mag / 8);
        ey = 8 * srange(mag / 8);
        fl = srange(mag);
        h = 8 * srange(mag / 8);
        k = $urandom_range(0, 10);
        k = k - 1;
        j = $urandom_range(0, 10);
        j = j - 1;
        px = ax + (ex / 8) * k;
        py = ay + (ey / 8) * k;
        pz = fl + (h / 8) * j;
        vx = srange(mag);
        vy = srange(mag);
        vz = srange(mag);
        a = $urandom_range(0, 5);
        a = a - 1;
        b = $urandom_range(0, 5);
        b = b - 1;
        return panel(ax, ay, ax + ex, ay + ey, fl, fl + h,
                     px - a * vx, py - a * vy, pz - a * vz,
                     px + b * vx, py + b * vy, pz + b * vz);
    endfunction

    function automatic panel_req_t random_panel();
        panel_req_t r;
        int mag, pick, m;
        case ($urandom_range(0, 2))
            0: mag = 1 << 10;
            1: mag = 1 << 16;
            default: mag = 1 << 22;
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            // raw noise over the full range of every field
            r = panel($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        else if (pick < 25)
        begin
            r = panel(pick_corner_value(), pick_corner_value(), pick_corner_value(),
                      pick_corner_value(), pick_corner_value(), pick_corner_value(),
                      pick_corner_value(), pick_corner_value(), pick_corner_value(),
                      pick_corner_value(), pick_corner_value(), pick_corner_value());
        end
        else if (pick < 35)
        begin
            // well formed but with one divisor forced to zero
            r = aimed_panel(mag);
            case ($urandom_range(0, 3))
                0: r.ce = r.fl;
                1:
                begin
                    r.bx = r.ax;
                    r.by = r.ay;
                end
                2:
                begin
                    r.tx = r.sx;
                    r.ty = r.sy;
                    r.tz = r.sz;
                end
                default:
                begin
                    m = srange(4);
                    r.tx = r.sx + ((r.bx - r.ax) / 8) * m;
                    r.ty = r.sy + ((r.by - r.ay) / 8) * m;
                end
            endcase
        end
        else
        begin
            r = aimed_panel(mag);
        end
        return r;
    endfunction

    task automatic report_fault(string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // drive one request at the falling edge and hold it until it is taken
    task automatic send_request(panel_req_t r);
        @(negedge clk);
        edge_ax = r.ax;
        edge_ay = r.ay;
        edge_bx = r.bx;
        edge_by = r.by;
        floor_z = r.fl;
        ceiling_z = r.ce;
        start_x = r.sx;
        start_y = r.sy;
        start_z = r.sz;
        end_x = r.tx;
        end_y = r.ty;
        end_z = r.tz;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        pending_verdicts.insert(pending_verdicts.size(), predict_crossing(r));
    endtask

    // lower valid for a number of cycles between bursts
    task automatic idle_sender(int cycles);
        @(negedge clk);
        in_valid = 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // response checker: compare against the oldest outstanding prediction
    always @(posedge clk)
    begin : check_response
        verdict_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_verdicts.size() == 0)
            begin
                report_fault($sformatf("unexpected response hit=%0b degenerate=%0b",
                                       hit, degenerate));
            end
            else
            begin
                want = pending_verdicts[0];
                pending_verdicts.delete(0);
                if (want.hit !== hit || want.degenerate !== degenerate)
                    report_fault($sformatf("expected hit=%0b degenerate=%0b, got hit=%0b degenerate=%0b",
                                           want.hit, want.degenerate, hit, degenerate));
            end
        end
    end

    // receiver stall pattern: each style runs for a random stretch before the next
    // is drawn; the long hold-off overrides everything
    always @(negedge clk)
    begin
        stall_tick++;
        if (stall_phase_left == 0)
        begin
            stall_style = stall_style_t'($urandom_range(0, 3));
            stall_phase_left = $urandom_range(20, 120);
        end
        else
        begin
            stall_phase_left--;
        end
        if (hold_active)
            out_stall = 1'b1;
        else if (!stall_enable)
            out_stall = 1'b0;
        else
            case (stall_style)
                STALL_LIGHT:    out_stall = ($urandom_range(0, 3) == 0);
                STALL_PERIODIC: out_stall = (stall_tick % 3 == 0);
                STALL_HEAVY:    out_stall = ($urandom_range(0, 3) != 0);
                default:        out_stall = 1'b0;
            endcase
    end

    // crossings right on the closed bounds of all three fractions
    task automatic test_boundaries();
        // mid-panel crossing
        send_request(panel(0, 0, 10*U, 0, 0, 10*U, 5*U, -5*U, 5*U, 5*U, 5*U, 5*U));
        // segment starts on the plane, line parameter zero
        send_request(panel(0, 0, 10*U, 0, 0, 10*U, 5*U, 0, 5*U, 5*U, 5*U, 5*U));
        // segment ends on the plane, line parameter one
        send_request(panel(0, 0, 10*U, 0, 0, 10*U, 5*U, -5*U, 5*U, 5*U, 0, 5*U));
        // stops short of the plane
        send_request(panel(0, 0, 10*U, 0, 0, 10*U, 5*U, -5*U, 5*U, 5*U, -U, 5*U));
        // crossing exactly at the edge start, then one lsb outside it
        send_request(panel(0, 0, 10*U, 0, 0, 10*U, 0, -5*U, 5*U, 0, 5*U, 5*U));
        send_request(panel(0, 0, 10*U, 0, 0, 10*U, -1, -5*U, 5*U, -1, 5*U, 5*U));
        // crossing exactly at the edge end
        send_request(panel(0, 0, 10*U, 0, 0, 10*U, 10*U, -5*U, 5*U, 10*U, 5*U, 5*U));
        // touching the floor, one lsb under it, touching the ceiling, one lsb over
        send_request(panel(0, 0, 10*U, 0, 0, 10*U, 5*U, -5*U, 0, 5*U, 5*U, 0));
        send_request(panel(0, 0, 10*U, 0, 0, 10*U, 5*U, -5*U, -1, 5*U, 5*U, -1));
        send_request(panel(0, 0, 10*U, 0, 0, 10*U, 5*U, -5*U, 10*U, 5*U, 5*U, 10*U));
        send_request(panel(0, 0, 10*U, 0, 0, 10*U, 5*U, -5*U, 10*U+1, 5*U, 5*U, 10*U+1));
        // reversed segment gives a negative divisor
        send_request(panel(0, 0, 10*U, 0, 0, 10*U, 5*U, 5*U, 5*U, 5*U, -5*U, 5*U));
        // ceiling below floor
        send_request(panel(0, 0, 10*U, 0, 10*U, 0, 5*U, -5*U, 5*U, 5*U, 5*U, 5*U));
        // slanted segment crossing at the panel center
        send_request(panel(0, 0, 10*U, 0, 0, 10*U, 3*U, -4*U, 0, 7*U, 4*U, 10*U));
    endtask

    // every way a divisor can vanish
    task automatic test_degenerate();
        // zero height
        send_request(panel(0, 0, 10*U, 0, 3*U, 3*U, 5*U, -5*U, 3*U, 5*U, 5*U, 3*U));
        // zero-length fence edge
        send_request(panel(2*U, 2*U, 2*U, 2*U, 0, 10*U, 5*U, -5*U, 5*U, 5*U, 5*U, 5*U));
        // zero-length segment
        send_request(panel(0, 0, 10*U, 0, 0, 10*U, 5*U, 0, 5*U, 5*U, 0, 5*U));
        // parallel to the panel, off the plane
        send_request(panel(0, 0, 10*U, 0, 0, 10*U, 0, -5*U, 5*U, 10*U, -5*U, 7*U));
        // lying inside the panel plane
        send_request(panel(0, 0, 10*U, 0, 0, 10*U, U, 0, U, 9*U, 0, 9*U));
    endtask

    // full-scale coordinates where the differences need the extra bit
    task automatic test_extremes();
        send_request(panel(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX,
                           CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
        send_request(panel(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
                           CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
        send_request(panel(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX,
                           CMIN, CMAX, CMIN, CMAX, CMIN, CMAX));
        send_request(panel(CMAX, CMIN, CMIN, CMAX, CMAX, CMIN,
                           CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
        send_request(panel(CMIN, 0, CMAX, 0, -1, CMAX,
                           0, CMIN, 0, 0, CMAX, 1));
    endtask

    // back-to-back requests with the receiver never stalling
    task automatic test_streaming();
        stall_enable = 1'b0;
        repeat (100) send_request(random_panel());
        stall_enable = 1'b1;
    endtask

    // bulk random traffic in bursts with random gaps
    task automatic test_random_mix();
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            burst = $urandom_range(1, 16);
            repeat (burst)
            begin
                send_request(random_panel());
                sent++;
            end
            gap = $urandom_range(0, 6);
            if (gap > 0)
                idle_sender(gap);
        end
    endtask

    // receiver holds off for a long stretch while requests keep coming, so
    // every stage fills and in_stall has to rise
    task automatic test_backpressure();
        fork
            begin
                @(posedge clk);
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active = 1'b0;
            end
        join_none
        repeat (60) send_request(random_panel());
    endtask

    initial
    begin
        int guard;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_boundaries();
        test_degenerate();
        test_extremes();
        test_streaming();
        test_random_mix();
        test_backpressure();

        @(negedge clk);
        in_valid = 1'b0;

        // drain, then watch a little longer for stray responses
        guard = 0;
        while (pending_verdicts.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
        if (pending_verdicts.size() != 0)
            report_fault($sformatf("%0d responses never arrived", pending_verdicts.size()));

        if (fault_count == 0)
            $display("** segment_vertical_panel_intersect_top: PASSED **");
        else
            $display("** segment_vertical_panel_intersect_top: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/svpi_pkg.sv
rtl/svpi_diff_mul.sv
rtl/svpi_cross_norm.sv
rtl/svpi_height.sv
rtl/svpi_decide.sv
rtl/segment_vertical_panel_intersect_top.sv
bench/tb.sv
